// ----- sv/i2cmra_pkg.sv -----
// Shared types and constants for the I2C master register access unit.
// No dependencies; imported by i2cmra_seq, i2c_master_register_access_unit and the testbench.
package i2cmra_pkg;

  // Sequencer stages, one-hot
  typedef enum logic [8:0] {
    ST_IDLE    = 9'b000000001,
    ST_START   = 9'b000000010,
    ST_DEV_W   = 9'b000000100,
    ST_REG     = 9'b000001000,
    ST_DATA    = 9'b000010000,
    ST_RESTART = 9'b000100000,
    ST_DEV_R   = 9'b001000000,
    ST_RECV    = 9'b010000000,
    ST_STOP    = 9'b100000000
  } stage_t;

  // Request action codes
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  // Bits in a byte, as a bit counter value
  localparam logic [3:0] BYTE_BITS = 4'd8;
  // Top bit of a byte (the 0x80 position), sent first
  localparam int unsigned MSB_POS = 7;
  // Read/write flag appended to the slave address
  localparam logic RW_WRITE = 1'b0;
  localparam logic RW_READ  = 1'b1;
  // Reset value of the slave address register
  localparam logic [6:0] DEV_ADDR_RESET = 7'd104;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] reg_address;
    logic [7:0] write_byte;
    logic [7:0] read_count;
    logic       sda_sample;
  } in_item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       byte_valid;
    logic [7:0] read_byte;
    logic       last_byte;
    logic       nack_seen;
  } out_item_t;

endpackage

// ----- sv/i2c_master_register_access_unit.sv -----
// Top level of the I2C master register access unit: request and result registers.
// Depends on i2cmra_pkg and i2cmra_seq.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------
//  in_     | input     | in_valid / in_stall    | in_item (in_item_t)
//  out_    | output    | out_valid / out_stall  | out_item (out_item_t)
//  cfg_    | input     | cfg_valid / cfg_ready  | cfg_data (slave address)
//
// Each request is one bus tick; one request per clock is sustained while
// out_stall is low, passing the request register, then the result register.
// The sequencer state steps once per request as it moves into the result register.
// rst_n is synchronous: empties both registers, sets the slave address to 104.
// in_stall rises only while the request register is full and the result
// register is held by out_stall. cfg_ready is always high.
module i2c_master_register_access_unit import i2cmra_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_item,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_item,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [6:0] cfg_data
);

  logic       in_vld_r;
  in_item_t   in_data_r;
  logic       out_vld_r;
  out_item_t  out_data_r;
  logic [6:0] dev_addr_r;
  logic       adv;
  logic       in_take;
  out_item_t  step_res;

  // Move a request on when the result register is free or draining
  assign adv      = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !adv;
  assign in_take  = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_vld_r;
  assign out_item  = out_data_r;

  i2cmra_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_en  (adv),
    .item     (in_data_r),
    .dev_addr (dev_addr_r),
    .res      (step_res)
  );

  // Hold the slave address
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= DEV_ADDR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      dev_addr_r <= cfg_data;
    end
  end

  // Request register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_take) begin
      in_vld_r <= 1'b1;
    end else if (adv) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_data_r <= in_item;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= step_res;
    end
  end

  // Input is held back only with a full pipe and a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (in_vld_r && out_vld_r && out_stall))
    else $error("input stalled without a blocked result");

  // A processed request always lands in the result register
  a_adv_lands: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_vld_r)
    else $error("processed request lost");

  // Received bytes and NACK flags appear only on busy SCL-high ticks
  a_flag_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && (out_data_r.byte_valid || out_data_r.nack_seen))
      |-> (out_data_r.busy_res && out_data_r.scl_level))
    else $error("flag on a wrong tick");

endmodule

// ----- sv/i2cmra_seq.sv -----
// Bus sequencer: transaction state and one-tick step logic for the I2C master.
// Depends on i2cmra_pkg for stage codes, action codes and item types.
module i2cmra_seq import i2cmra_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step_en,
  input  in_item_t   item,
  input  logic [6:0] dev_addr,
  output out_item_t  res
);

  stage_t     stage_r, stage_nxt, cur_stage;
  logic [3:0] bit_r, bit_nxt, cur_bit;
  logic       phase_r, phase_nxt, cur_phase;
  logic [7:0] shift_r, shift_nxt;
  logic [7:0] left_r, left_nxt;
  logic [7:0] reg_addr_r, reg_addr_nxt;
  logic [7:0] wr_byte_r, wr_byte_nxt;
  logic       is_read_r, is_read_nxt;
  logic [7:0] shift_in;

  // Work out one bus tick
  always_comb begin
    stage_nxt    = stage_r;
    bit_nxt      = bit_r;
    phase_nxt    = phase_r;
    shift_nxt    = shift_r;
    left_nxt     = left_r;
    reg_addr_nxt = reg_addr_r;
    wr_byte_nxt  = wr_byte_r;
    is_read_nxt  = is_read_r;
    res            = '0;
    res.scl_level  = 1'b1;
    res.sda_level  = 1'b1;
    res.busy_res   = 1'b1;
    shift_in       = {shift_r[6:0], item.sda_sample};

    cur_stage = stage_r;
    cur_bit   = bit_r;
    cur_phase = phase_r;

    // Take a command only when idle; it becomes the first start tick
    if (stage_r == ST_IDLE && (item.action == ACT_WRITE || item.action == ACT_READ)) begin
      reg_addr_nxt = item.reg_address;
      wr_byte_nxt  = item.write_byte;
      left_nxt     = (item.read_count == 8'd0) ? 8'd1 : item.read_count;
      is_read_nxt  = (item.action == ACT_READ);
      cur_stage    = ST_START;
      cur_bit      = 4'd0;
      cur_phase    = 1'b0;
    end

    stage_nxt = cur_stage;
    bit_nxt   = cur_bit;
    phase_nxt = cur_phase;

    unique case (cur_stage)
      ST_START: begin
        if (!cur_phase) begin
          phase_nxt = 1'b1;
        end else begin
          res.sda_level = 1'b0;
          stage_nxt = ST_DEV_W;
          shift_nxt = {dev_addr, RW_WRITE};
          bit_nxt   = 4'd0;
          phase_nxt = 1'b0;
        end
      end
      ST_DEV_W, ST_REG, ST_DATA, ST_DEV_R: begin
        if (cur_bit < BYTE_BITS) begin
          // Send a data bit, MSB first
          res.sda_level = shift_r[MSB_POS];
          if (!cur_phase) begin
            res.scl_level = 1'b0;
            phase_nxt = 1'b1;
          end else begin
            shift_nxt = {shift_r[6:0], 1'b0};
            bit_nxt   = cur_bit + 4'd1;
            phase_nxt = 1'b0;
          end
        end else if (!cur_phase) begin
          res.scl_level = 1'b0;
          phase_nxt = 1'b1;
        end else begin
          // Slave ACK slot: flag a NACK and carry on
          res.nack_seen = item.sda_sample;
          bit_nxt   = 4'd0;
          phase_nxt = 1'b0;
          if (cur_stage == ST_DEV_W) begin
            stage_nxt = ST_REG;
            shift_nxt = reg_addr_r;
          end else if (cur_stage == ST_REG) begin
            stage_nxt = is_read_r ? ST_RESTART : ST_DATA;
            shift_nxt = wr_byte_r;
          end else if (cur_stage == ST_DATA) begin
            stage_nxt = ST_STOP;
            shift_nxt = 8'd0;
          end else begin
            stage_nxt = ST_RECV;
            shift_nxt = 8'd0;
          end
        end
      end
      ST_RESTART: begin
        if (cur_bit == 4'd0) begin
          res.scl_level = 1'b0;
          bit_nxt = 4'd1;
        end else if (cur_bit == 4'd1) begin
          bit_nxt = 4'd2;
        end else begin
          res.sda_level = 1'b0;
          stage_nxt = ST_DEV_R;
          shift_nxt = {dev_addr, RW_READ};
          bit_nxt   = 4'd0;
          phase_nxt = 1'b0;
        end
      end
      ST_RECV: begin
        if (cur_bit < BYTE_BITS) begin
          if (!cur_phase) begin
            res.scl_level = 1'b0;
            phase_nxt = 1'b1;
          end else begin
            // Sample the slave on SCL high
            shift_nxt = shift_in;
            bit_nxt   = cur_bit + 4'd1;
            phase_nxt = 1'b0;
            if (cur_bit == BYTE_BITS - 4'd1) begin
              res.byte_valid = 1'b1;
              res.read_byte  = shift_in;
              res.last_byte  = (left_r <= 8'd1);
            end
          end
        end else begin
          // Master ACK, or NACK on the final byte
          res.sda_level = (left_r <= 8'd1);
          if (!cur_phase) begin
            res.scl_level = 1'b0;
            phase_nxt = 1'b1;
          end else begin
            shift_nxt = 8'd0;
            bit_nxt   = 4'd0;
            phase_nxt = 1'b0;
            if (left_r <= 8'd1) begin
              left_nxt  = 8'd0;
              stage_nxt = ST_STOP;
            end else begin
              left_nxt  = left_r - 8'd1;
              stage_nxt = ST_RECV;
            end
          end
        end
      end
      ST_STOP: begin
        res.sda_level = 1'b0;
        if (cur_bit == 4'd0) begin
          res.scl_level = 1'b0;
          bit_nxt = 4'd1;
        end else begin
          stage_nxt = ST_IDLE;
          bit_nxt   = 4'd0;
          phase_nxt = 1'b0;
        end
      end
      default: begin
        stage_nxt    = ST_IDLE;
        bit_nxt      = 4'd0;
        phase_nxt    = 1'b0;
        res.busy_res = 1'b0;
      end
    endcase
  end

  // Advance the state on each processed request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r    <= ST_IDLE;
      bit_r      <= 4'd0;
      phase_r    <= 1'b0;
      shift_r    <= 8'd0;
      left_r     <= 8'd0;
      reg_addr_r <= 8'd0;
      wr_byte_r  <= 8'd0;
      is_read_r  <= 1'b0;
    end else if (step_en) begin
      stage_r    <= stage_nxt;
      bit_r      <= bit_nxt;
      phase_r    <= phase_nxt;
      shift_r    <= shift_nxt;
      left_r     <= left_nxt;
      reg_addr_r <= reg_addr_nxt;
      wr_byte_r  <= wr_byte_nxt;
      is_read_r  <= is_read_nxt;
    end
  end

  // Bit counter never runs past a full byte
  a_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
    bit_r <= BYTE_BITS)
    else $error("bit counter out of range");

  // A burst read always has a byte to go while receiving
  a_recv_left: assert property (@(posedge clk) disable iff (!rst_n)
    (stage_r == ST_RECV) |-> (left_r != 8'd0))
    else $error("receiving with no bytes left");

  // Idle holds the counters cleared
  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (stage_r == ST_IDLE) |-> (bit_r == 4'd0 && !phase_r))
    else $error("idle with live counters");

endmodule

// ----- test/tb_i2c_master_register_access_unit.sv -----
// Self-checking testbench for the I2C master register access unit: directed table,
// then random bus traffic, every result checked against a bus sequencer predictor or a typed-in result.
// Depends on i2cmra_pkg and i2c_master_register_access_unit.
`timescale 1ns / 100ps

module tb_i2c_master_register_access_unit;
  import i2cmra_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 11;
  localparam int CYCLE_LIMIT    = 2_000_000;
  localparam int PHASES         = 4;
  localparam int PHASE_REQUESTS = 40;
  localparam int LONG_HOLD_AT   = 300;
  localparam int LONG_HOLD      = 150;
  // Action code with no meaning of its own; the block treats it as a tick
  localparam logic [1:0] ACT_SPARE = 2'd3;

  // Receiver stall modes
  localparam logic [1:0] RX_FREE     = 2'd0;
  localparam logic [1:0] RX_RANDOM   = 2'd1;
  localparam logic [1:0] RX_PERIODIC = 2'd2;

  // Bus levels that can be read off directly
  localparam out_item_t IDLE_BUS = out_item_t'{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0};
  localparam out_item_t CMD_BUS  = out_item_t'{1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0};

  // One directed row: request, chance in percent of SDA high while the
  // transaction runs out, and an optional typed-in result
  typedef struct packed {
    in_item_t   req;
    logic [6:0] sda_pct;
    logic       typed;
    out_item_t  typed_res;
  } dir_row_t;

  localparam int DIR_ROWS = 10;
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    dir_row_t'{in_item_t'{ACT_TICK,  8'h00, 8'h00, 8'h00, 1'b0}, 7'd0,   1'b1, IDLE_BUS},
    dir_row_t'{in_item_t'{ACT_SPARE, 8'hFF, 8'hFF, 8'hFF, 1'b1}, 7'd0,   1'b1, IDLE_BUS},
    dir_row_t'{in_item_t'{ACT_WRITE, 8'h00, 8'hFF, 8'h01, 1'b0}, 7'd0,   1'b1, CMD_BUS},
    dir_row_t'{in_item_t'{ACT_WRITE, 8'hFF, 8'h00, 8'hFF, 1'b1}, 7'd100, 1'b1, CMD_BUS},
    dir_row_t'{in_item_t'{ACT_READ,  8'hA5, 8'h00, 8'h01, 1'b0}, 7'd50,  1'b0, IDLE_BUS},
    dir_row_t'{in_item_t'{ACT_READ,  8'h3C, 8'h5A, 8'h00, 1'b1}, 7'd100, 1'b0, IDLE_BUS},
    dir_row_t'{in_item_t'{ACT_READ,  8'h00, 8'hFF, 8'h02, 1'b0}, 7'd0,   1'b0, IDLE_BUS},
    dir_row_t'{in_item_t'{ACT_READ,  8'h81, 8'h7E, 8'h03, 1'b1}, 7'd50,  1'b0, IDLE_BUS},
    dir_row_t'{in_item_t'{ACT_WRITE, 8'h5A, 8'hA5, 8'h80, 1'b0}, 7'd50,  1'b0, IDLE_BUS},
    dir_row_t'{in_item_t'{ACT_TICK,  8'h00, 8'h00, 8'h00, 1'b1}, 7'd0,   1'b1, IDLE_BUS}
  };

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [6:0] cfg_data;

  // Predictor copy of the register and the sequencer
  logic [6:0] slave_addr;
  stage_t     seq_stage;
  logic [3:0] seq_bit;
  logic       seq_phase;
  logic [7:0] seq_shift;
  logic [7:0] seq_bytes_left;
  logic [7:0] seq_reg;
  logic [7:0] seq_wdata;
  logic       seq_is_read;

  out_item_t bus_levels_q [$];
  int        mismatch_count = 0;
  int        result_count   = 0;
  int        accepted_count = 0;
  int        cycle_count    = 0;
  int        burst_left     = 0;
  bit        long_hold_done = 1'b0;

  i2c_master_register_access_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Load the next byte to shift and restart its bit count
  function automatic void load_byte(stage_t nxt_stage, logic [7:0] value);
    seq_stage = nxt_stage;
    seq_shift = value;
    seq_bit   = '0;
    seq_phase = 1'b0;
  endfunction

  // Advance the sequencer by one bus tick and return the levels it drives
  function automatic out_item_t step_bus_sequencer(in_item_t req);
    out_item_t r;
    r = '0;
    r.scl_level = 1'b1;
    r.sda_level = 1'b1;
    r.busy_res  = 1'b1;

    // Latch a command only while idle
    if (seq_stage == ST_IDLE && (req.action == ACT_WRITE || req.action == ACT_READ)) begin
      seq_reg        = req.reg_address;
      seq_wdata      = req.write_byte;
      seq_bytes_left = (req.read_count == 8'd0) ? 8'd1 : req.read_count;
      seq_is_read    = (req.action == ACT_READ);
      seq_stage      = ST_START;
      seq_bit        = '0;
      seq_phase      = 1'b0;
    end

    case (seq_stage)
      ST_START: begin
        if (!seq_phase) begin
          seq_phase = 1'b1;
        end else begin
          r.sda_level = 1'b0;
          load_byte(ST_DEV_W, {slave_addr, RW_WRITE});
        end
      end
      ST_DEV_W, ST_REG, ST_DATA, ST_DEV_R: begin
        if (seq_bit < BYTE_BITS) begin
          r.sda_level = seq_shift[MSB_POS];
          if (!seq_phase) begin
            r.scl_level = 1'b0;
            seq_phase   = 1'b1;
          end else begin
            seq_shift = seq_shift << 1;
            seq_bit++;
            seq_phase = 1'b0;
          end
        end else if (!seq_phase) begin
          r.scl_level = 1'b0;
          seq_phase   = 1'b1;
        end else begin
          // Acknowledge slot: flag a high line and carry on
          r.nack_seen = req.sda_sample;
          case (seq_stage)
            ST_DEV_W: load_byte(ST_REG, seq_reg);
            ST_REG: begin
              if (seq_is_read) load_byte(ST_RESTART, seq_wdata);
              else load_byte(ST_DATA, seq_wdata);
            end
            ST_DATA: load_byte(ST_STOP, 8'h00);
            default: load_byte(ST_RECV, 8'h00);
          endcase
        end
      end
      ST_RESTART: begin
        if (seq_bit == 4'd0) begin
          r.scl_level = 1'b0;
          seq_bit     = 4'd1;
        end else if (seq_bit == 4'd1) begin
          seq_bit = 4'd2;
        end else begin
          r.sda_level = 1'b0;
          load_byte(ST_DEV_R, {slave_addr, RW_READ});
        end
      end
      ST_RECV: begin
        if (seq_bit < BYTE_BITS) begin
          if (!seq_phase) begin
            r.scl_level = 1'b0;
            seq_phase   = 1'b1;
          end else begin
            seq_shift = {seq_shift[6:0], req.sda_sample};
            seq_bit++;
            seq_phase = 1'b0;
            if (seq_bit == BYTE_BITS) begin
              r.byte_valid = 1'b1;
              r.read_byte  = seq_shift;
              r.last_byte  = (seq_bytes_left <= 8'd1);
            end
          end
        end else begin
          // Master ACK on all but the last byte, NACK on the last
          r.sda_level = (seq_bytes_left <= 8'd1);
          if (!seq_phase) begin
            r.scl_level = 1'b0;
            seq_phase   = 1'b1;
          end else if (seq_bytes_left <= 8'd1) begin
            seq_bytes_left = 8'd0;
            load_byte(ST_STOP, 8'h00);
          end else begin
            seq_bytes_left--;
            load_byte(ST_RECV, 8'h00);
          end
        end
      end
      ST_STOP: begin
        r.sda_level = 1'b0;
        if (seq_bit == 4'd0) begin
          r.scl_level = 1'b0;
          seq_bit     = 4'd1;
        end else begin
          seq_stage = ST_IDLE;
          seq_bit   = '0;
          seq_phase = 1'b0;
        end
      end
      default: begin
        seq_stage  = ST_IDLE;
        seq_bit    = '0;
        seq_phase  = 1'b0;
        r.busy_res = 1'b0;
      end
    endcase
    return r;
  endfunction

  // Plain tick with random fields; some carry a command the busy block ignores
  function automatic in_item_t make_tick(int sda_pct);
    in_item_t t;
    t = in_item_t'($urandom);
    if ($urandom_range(0, 3) != 0) t.action = ACT_TICK;
    t.sda_sample = ($urandom_range(0, 99) < sda_pct);
    return t;
  endfunction

  // Offer one request in bursts with random gaps; predict on acceptance
  task automatic offer_request(input in_item_t req, input logic typed,
                               input out_item_t typed_res);
    int        gap;
    out_item_t predicted;
    if (burst_left == 0) begin
      if ($urandom_range(0, 4) == 0) begin
        gap        = 0;
        burst_left = $urandom_range(40, 120);
      end else begin
        gap        = $urandom_range(1, 6);
        burst_left = $urandom_range(1, 16);
      end
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_item  <= req;
    do @(posedge clk); while (in_stall);
    accepted_count++;
    predicted = step_bus_sequencer(req);
    bus_levels_q.push_back(typed ? typed_res : predicted);
  endtask

  // Drop valid and hold until every expected result has arrived
  task automatic pause_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (bus_levels_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_slave_address(input logic [6:0] addr);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= addr;
    do @(posedge clk); while (!cfg_ready);
    slave_addr = addr;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    mismatch_count++;
    $display("%0t: result %0d %s: got %0h, expected %0h",
             $time, result_count, what, got, want);
  endtask

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (bus_levels_q.size() == 0) begin
        report_mismatch("unexpected result", 8'h00, 8'h00);
      end else begin
        want = bus_levels_q.pop_front();
        if (out_item.scl_level !== want.scl_level)
          report_mismatch("scl_level", 8'(out_item.scl_level), 8'(want.scl_level));
        if (out_item.sda_level !== want.sda_level)
          report_mismatch("sda_level", 8'(out_item.sda_level), 8'(want.sda_level));
        if (out_item.busy_res !== want.busy_res)
          report_mismatch("busy_res", 8'(out_item.busy_res), 8'(want.busy_res));
        if (out_item.byte_valid !== want.byte_valid)
          report_mismatch("byte_valid", 8'(out_item.byte_valid), 8'(want.byte_valid));
        if (out_item.read_byte !== want.read_byte)
          report_mismatch("read_byte", out_item.read_byte, want.read_byte);
        if (out_item.last_byte !== want.last_byte)
          report_mismatch("last_byte", 8'(out_item.last_byte), 8'(want.last_byte));
        if (out_item.nack_seen !== want.nack_seen)
          report_mismatch("nack_seen", 8'(out_item.nack_seen), 8'(want.nack_seen));
      end
      result_count++;
    end
  end

  // Stall the result channel on a pattern of its own, with one long hold-off
  initial begin
    logic [1:0] rx_mode;
    int         mode_left;
    mode_left = 0;
    rx_mode   = RX_FREE;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!long_hold_done && accepted_count >= LONG_HOLD_AT) begin
        long_hold_done = 1'b1;
        repeat (LONG_HOLD) begin
          out_stall <= 1'b1;
          @(negedge clk);
        end
      end
      if (mode_left == 0) begin
        rx_mode   = 2'($urandom_range(0, 2));
        mode_left = $urandom_range(16, 80);
      end
      case (rx_mode)
        RX_RANDOM:   out_stall <= ($urandom_range(0, 2) == 0);
        RX_PERIODIC: out_stall <= (mode_left % 4 == 0);
        default:     out_stall <= 1'b0;
      endcase
      mode_left--;
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, bus_levels_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    in_item_t   req;
    int         issued;
    int         sda_pct;
    int         pick;
    logic [6:0] addr;

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_item   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;

    slave_addr     = DEV_ADDR_RESET;
    seq_stage      = ST_IDLE;
    seq_bit        = '0;
    seq_phase      = 1'b0;
    seq_shift      = '0;
    seq_bytes_left = '0;
    seq_reg        = '0;
    seq_wdata      = '0;
    seq_is_read    = 1'b0;
    sda_pct        = 50;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Walk the directed table at the reset address; run each transaction out
    for (int i = 0; i < DIR_ROWS; i++) begin
      offer_request(DIR_TABLE[i].req, DIR_TABLE[i].typed, DIR_TABLE[i].typed_res);
      while (seq_stage != ST_IDLE)
        offer_request(make_tick(int'(DIR_TABLE[i].sda_pct)), 1'b0, IDLE_BUS);
    end

    // Random phases, each at its own slave address
    for (int p = 0; p < PHASES; p++) begin
      pause_until_drained();
      case (p)
        0:       addr = 7'h00;
        1:       addr = 7'h7F;
        2:       addr = 7'h55;
        3:       addr = 7'h2A;
        default: addr = 7'($urandom);
      endcase
      write_slave_address(addr);

      issued = 0;
      while (issued < PHASE_REQUESTS) begin
        // Once, hold the sender until the block has emptied
        if (p == 1 && issued == PHASE_REQUESTS / 2) pause_until_drained();
        if (seq_stage == ST_IDLE) begin
          req = in_item_t'($urandom);
          if ($urandom_range(0, 9) < 7) begin
            req.action = $urandom_range(0, 1) ? ACT_READ : ACT_WRITE;
            pick = $urandom_range(0, 99);
            if (pick < 85) req.read_count = 8'($urandom_range(1, 4));
            else if (pick < 97) req.read_count = 8'($urandom_range(0, 15));
            else req.read_count = 8'($urandom_range(16, 20));
            case ($urandom_range(0, 3))
              0:       sda_pct = 0;
              1:       sda_pct = 5;
              2:       sda_pct = 50;
              default: sda_pct = 100;
            endcase
          end else begin
            req.action = $urandom_range(0, 1) ? ACT_TICK : ACT_SPARE;
          end
        end else begin
          req = make_tick(sda_pct);
        end
        offer_request(req, 1'b0, IDLE_BUS);
        issued++;
      end
      while (seq_stage != ST_IDLE)
        offer_request(make_tick(sda_pct), 1'b0, IDLE_BUS);
    end

    pause_until_drained();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
